@@ rtl/swrf_pkg.sv @@
// Shared constants of the sliding window rank filter.
`default_nettype none
package swrf_pkg;

   // field widths of the stream words
   localparam int JOINT_W = 5;
   localparam int QTY_W   = 4;
   localparam int DATA_W  = 32;
   localparam int RANK_W  = 5;

   // packed words, padded to whole bytes
   localparam int FIELDS_W = JOINT_W + QTY_W + DATA_W;
   localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

   // default geometry
   localparam int WINDOW_SIZE_DEF    = 5;
   localparam int JOINT_COUNT_DEF    = 32;
   localparam int QUANTITY_COUNT_DEF = 16;

   // rank after reset: median of the default window
   localparam logic [RANK_W-1:0] RANK_RESET = 5'd2;

endpackage
`default_nettype wire

@@ rtl/sliding_window_rank_filter.sv @@
// Top level of the sliding window rank filter: window memory, compare stage, write back.
//
// Keeps a sorted window of the last WINDOW_SIZE samples for every joint and
// quantity channel, one memory row per channel, each slot tagged with its age.
// A sample ages its channel's slots, replaces the oldest one and is slid into
// sorted position; the response word carries the value at the configured rank
// (median at the reset rank) with the joint and quantity echoed. The row is
// read at acceptance, compared in the compare state and then written back in
// the write state (a read/modify/write of one row per word), which also loads
// the response and waits while the held response is not taken; a new word is
// accepted no sooner than the last one's write back. A word for the channel
// just written is forwarded from the write register. After reset a clearing
// pass over every row initializes the memory, during which no word is accepted
// (rank writes are taken). Samples for a joint or quantity outside the
// configured counts leave the memory alone and return zero. Ranks at or above
// WINDOW_SIZE read the last slot. Write the rank only while the block is idle.
`default_nettype none
module sliding_window_rank_filter #(
   parameter int WINDOW_SIZE    = swrf_pkg::WINDOW_SIZE_DEF,
   parameter int JOINT_COUNT    = swrf_pkg::JOINT_COUNT_DEF,
   parameter int QUANTITY_COUNT = swrf_pkg::QUANTITY_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // sample words
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // joint_index, quantity_index, sample, zero pad
   input  wire logic [swrf_pkg::TDATA_W-1:0] req_tdata,
   // result words
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // filtered_value, joint_echo, quantity_echo, zero pad
   output logic [swrf_pkg::TDATA_W-1:0]      rsp_tdata,
   // rank register
   input  wire logic                         csr_wr_en,
   input  wire logic [swrf_pkg::RANK_W-1:0]  csr_wr_data
);

   localparam int CHANNELS = JOINT_COUNT * QUANTITY_COUNT;
   localparam int CHAN_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W    = $clog2(WINDOW_SIZE);
   localparam int JW       = swrf_pkg::JOINT_W;
   localparam int QW       = swrf_pkg::QTY_W;
   localparam int DW       = swrf_pkg::DATA_W;
   localparam int PAD_W    = swrf_pkg::TDATA_W - swrf_pkg::FIELDS_W;

   typedef struct packed {
      logic [IDX_W-1:0]  age;
      logic signed [DW-1:0] value;
   } lane_type;

   typedef lane_type [WINDOW_SIZE-1:0] row_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_CALC,
      S_WRITE
   } state_type;

   state_type state_ff, state_in;

   // window memory, one row per channel
   row_type mem [CHANNELS];
   row_type rd_row_ff;

   logic              wr_en;
   logic [CHAN_W-1:0] wr_addr;
   row_type           wr_data;

   logic [CHAN_W-1:0] clr_cnt_ff;

   // item under work
   logic [JW-1:0]        joint_ff;
   logic [QW-1:0]        qty_ff;
   logic signed [DW-1:0] sample_ff;
   logic [CHAN_W-1:0]    chan_ff;
   logic                 inrange_ff;

   // forwarding of the last written row
   row_type wr_row_ff;
   logic    fwd_ff, fwd_in;

   // compare stage results
   row_type                vals_ff, vals_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic                   down_ff, down_in;
   logic [WINDOW_SIZE-1:0] gt_ff, gt_in;
   logic [WINDOW_SIZE-1:0] lt_ff, lt_in;

   logic [swrf_pkg::RANK_W-1:0] rank_ff;
   logic [IDX_W-1:0]            rank_eff;

   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [swrf_pkg::TDATA_W-1:0] rsp_tdata_ff;

   // input decode
   logic [JW-1:0]        req_joint;
   logic [QW-1:0]        req_qty;
   logic signed [DW-1:0] req_sample;
   logic [CHAN_W-1:0]    req_chan;
   logic                 req_inrange;
   logic                 req_acc;
   logic                 out_free;

   row_type  init_row;
   row_type  row_c;
   row_type  new_row;
   row_type  row_prev;
   row_type  row_next;
   logic [WINDOW_SIZE-1:0] gt_prev;
   logic [WINDOW_SIZE-1:0] lt_next;
   lane_type lane_zero;
   logic signed [DW-1:0] old_c;
   logic signed [DW-1:0] result_c;
   logic                 do_write;

   assign req_joint  = req_tdata[JW-1:0];
   assign req_qty    = req_tdata[JW+QW-1:JW];
   assign req_sample = $signed(req_tdata[JW+QW+DW-1:JW+QW]);
   assign req_chan   = CHAN_W'(int'(req_joint) * QUANTITY_COUNT + int'(req_qty));
   assign req_inrange = ({2'b00, req_joint} < (JW+2)'(JOINT_COUNT)) &&
                        ({1'b0, req_qty} < (QW+1)'(QUANTITY_COUNT));

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || (state_ff == S_WRITE && out_free);
   assign req_acc    = req_tvalid && req_tready;
   assign do_write   = (state_ff == S_WRITE) && out_free;

   assign rank_eff = ({1'b0, rank_ff} >= (swrf_pkg::RANK_W+1)'(WINDOW_SIZE)) ?
                     IDX_W'(WINDOW_SIZE - 1) : rank_ff[IDX_W-1:0];

   always_comb begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         init_row[j].age   = IDX_W'(j);
         init_row[j].value = '0;
      end
   end

   // compare stage: age the row, find the oldest slot, compare against the sample
   always_comb begin
      row_c   = fwd_ff ? wr_row_ff : rd_row_ff;
      pos_in  = '0;
      old_c   = '0;
      vals_in = row_c;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         if (row_c[j].age == IDX_W'(WINDOW_SIZE - 1)) begin
            pos_in  = pos_in | IDX_W'(j);
            old_c   = old_c | row_c[j].value;
            vals_in[j].age = '0;
         end else begin
            vals_in[j].age = row_c[j].age + 1'b1;
         end
         gt_in[j] = $signed(row_c[j].value) > sample_ff;
         lt_in[j] = $signed(row_c[j].value) < sample_ff;
      end
      down_in = sample_ff < old_c;
   end

   // write stage: each slot takes its neighbor, the sample, or keeps its entry
   assign lane_zero = '0;
   assign row_prev  = {vals_ff[WINDOW_SIZE-2:0], lane_zero};
   assign row_next  = {lane_zero, vals_ff[WINDOW_SIZE-1:1]};
   assign gt_prev   = {gt_ff[WINDOW_SIZE-2:0], 1'b0};
   assign lt_next   = {1'b0, lt_ff[WINDOW_SIZE-1:1]};

   always_comb begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         new_row[j] = vals_ff[j];
         if (down_ff) begin
            if (IDX_W'(j) <= pos_ff) begin
               if (gt_prev[j]) begin
                  new_row[j] = row_prev[j];
               end else if (IDX_W'(j) == pos_ff || gt_ff[j]) begin
                  new_row[j].value = sample_ff;
                  new_row[j].age   = '0;
               end
            end
         end else begin
            if (IDX_W'(j) >= pos_ff) begin
               if (lt_next[j]) begin
                  new_row[j] = row_next[j];
               end else if (IDX_W'(j) == pos_ff || lt_ff[j]) begin
                  new_row[j].value = sample_ff;
                  new_row[j].age   = '0;
               end
            end
         end
      end
      result_c = inrange_ff ? new_row[rank_eff].value : '0;
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chan_ff;
      wr_data = new_row;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = init_row;
      end else if (do_write && inrange_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_acc) begin
         rd_row_ff <= mem[req_chan];
      end
   end

   // control
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      fwd_in        = fwd_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == CHAN_W'(CHANNELS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_CALC;
               fwd_in   = 1'b0;
            end
         end
         S_CALC: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = req_acc ? S_CALC : S_IDLE;
               // same channel read while its row is written: take the new row
               fwd_in        = inrange_ff && (req_chan == chan_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
         fwd_ff        <= 1'b0;
         rank_ff       <= swrf_pkg::RANK_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         fwd_ff        <= fwd_in;
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (csr_wr_en) begin
            rank_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         joint_ff   <= req_joint;
         qty_ff     <= req_qty;
         sample_ff  <= req_sample;
         chan_ff    <= req_chan;
         inrange_ff <= req_inrange;
      end
      if (state_ff == S_CALC) begin
         vals_ff <= vals_in;
         pos_ff  <= pos_in;
         down_ff <= down_in;
         gt_ff   <= gt_in;
         lt_ff   <= lt_in;
      end
      if (do_write) begin
         wr_row_ff    <= new_row;
         rsp_tdata_ff <= {{PAD_W{1'b0}}, qty_ff, joint_ff, result_c};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

@@ test/sliding_window_rank_filter_tb.sv @@
// Self-checking testbench for the sliding window rank filter: stream driver, monitor, predictor.
`default_nettype none
module sliding_window_rank_filter_tb;
   import swrf_pkg::*;

   localparam int WIN       = WINDOW_SIZE_DEF;
   localparam int JOINTS    = JOINT_COUNT_DEF;
   localparam int QTYS      = QUANTITY_COUNT_DEF;
   localparam int CHANNELS  = JOINTS * QTYS;
   localparam int PAD_W     = TDATA_W - FIELDS_W;
   localparam int HOLD_LEN  = 300;
   localparam int STALL_MAX = 2000;
   localparam int HOT_COUNT = 6;

   // joint sits in the lowest bits, as on req_tdata
   typedef struct packed {
      logic signed [DATA_W-1:0] smp;
      logic [QTY_W-1:0]         qty;
      logic [JOINT_W-1:0]       joint;
   } sample_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [JOINT_W-1:0]       joint;
      logic [QTY_W-1:0]         qty;
   } filtered_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // joint_index, quantity_index, sample, zero pad
   logic [TDATA_W-1:0]  req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // filtered_value, joint_echo, quantity_echo, zero pad
   logic [TDATA_W-1:0]  rsp_tdata;
   logic                csr_wr_en = 1'b0;
   logic [RANK_W-1:0]   csr_wr_data = '0;

   sliding_window_rank_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // predictor state: one sorted window per channel
   logic signed [DATA_W-1:0] win_value [CHANNELS][WIN];
   int unsigned              win_age   [CHANNELS][WIN];
   logic [RANK_W-1:0]        rank_setting = RANK_RESET;

   sample_word_type   pending_samples[$];
   filtered_word_type expected_ranks[$];
   int             mismatch_count = 0;
   bit             idle_on = 1'b0;
   int             holds_asked = 0;

   logic [JOINT_W-1:0] hot_joint [HOT_COUNT];
   logic [QTY_W-1:0]   hot_qty   [HOT_COUNT];

   function automatic filtered_word_type predict_rank(sample_word_type w);
      filtered_word_type        r;
      int                       ch;
      int                       pos;
      int                       sel;
      bit                       down;
      logic signed [DATA_W-1:0] tv;
      int unsigned              ta;
      r.joint = w.joint;
      r.qty   = w.qty;
      r.value = '0;
      if (w.joint < JOINTS && w.qty < QTYS) begin
         ch   = w.joint * QTYS + w.qty;
         pos  = 0;
         down = 1'b0;
         for (int i = 0; i < WIN; i++) begin
            win_age[ch][i] = win_age[ch][i] + 1;
            if (win_age[ch][i] == WIN) begin
               pos = i;
               down = w.smp < win_value[ch][i];
               win_age[ch][i] = 0;
               win_value[ch][i] = w.smp;
            end
         end
         if (down) begin
            for (int i = pos; i > 0; i--) begin
               if (win_value[ch][i-1] > win_value[ch][i]) begin
                  tv = win_value[ch][i-1]; ta = win_age[ch][i-1];
                  win_value[ch][i-1] = win_value[ch][i]; win_age[ch][i-1] = win_age[ch][i];
                  win_value[ch][i] = tv; win_age[ch][i] = ta;
               end else
                  break;
            end
         end else begin
            for (int i = pos; i + 1 < WIN; i++) begin
               if (win_value[ch][i+1] < win_value[ch][i]) begin
                  tv = win_value[ch][i+1]; ta = win_age[ch][i+1];
                  win_value[ch][i+1] = win_value[ch][i]; win_age[ch][i+1] = win_age[ch][i];
                  win_value[ch][i] = tv; win_age[ch][i] = ta;
               end else
                  break;
            end
         end
         sel = (rank_setting >= WIN) ? WIN - 1 : int'(rank_setting);
         r.value = win_value[ch][sel];
      end
      return r;
   endfunction

   // acceptance flags for the negedge drivers
   logic req_fire = 1'b0;
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
   end

   // sender
   int req_gap = 0;
   always @(negedge clock) begin
      sample_word_type w;
      if (reset)
         req_tvalid <= 1'b0;
      else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            w = pending_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {{PAD_W{1'b0}}, w.smp, w.qty, w.joint};
            if (idle_on && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 6);
         end else
            req_tvalid <= 1'b0;
      end
   end

   // receiver: random stalls plus long hold-offs on request
   int hold_left = 0;
   int stall_left = 0;
   int holds_served = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_served + 1;
         hold_left = HOLD_LEN - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   // monitor, scoreboard and watchdog
   int quiet_cycles = 0;
   always @(posedge clock) begin
      filtered_word_type want;
      filtered_word_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_ranks.push_back(
               predict_rank(sample_word_type'(req_tdata[FIELDS_W-1:0])));
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[DATA_W-1:0];
            got.joint = rsp_tdata[DATA_W +: JOINT_W];
            got.qty   = rsp_tdata[DATA_W+JOINT_W +: QTY_W];
            if (expected_ranks.size() == 0) begin
               $error("result word with nothing expected: value %0d", got.value);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_ranks.pop_front();
               if (got.value !== want.value) begin
                  $error("filtered_value: expected %0d, got %0d", want.value, got.value);
                  mismatch_count = mismatch_count + 1;
               end
               if (got.joint !== want.joint) begin
                  $error("joint_echo: expected %0d, got %0d", want.joint, got.joint);
                  mismatch_count = mismatch_count + 1;
               end
               if (got.qty !== want.qty) begin
                  $error("quantity_echo: expected %0d, got %0d", want.qty, got.qty);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic sample_word_type random_sample();
      sample_word_type w;
      int              k;
      if ($urandom_range(0, 9) < 7) begin
         k = $urandom_range(0, HOT_COUNT - 1);
         w.joint = hot_joint[k];
         w.qty   = hot_qty[k];
      end else begin
         w.joint = JOINT_W'($urandom_range(0, JOINTS - 1));
         w.qty   = QTY_W'($urandom_range(0, QTYS - 1));
      end
      k = $urandom_range(0, 9);
      if (k < 4)
         w.smp = $signed($urandom_range(0, 8)) - 4;   // small range, lots of ties
      else if (k < 6)
         case ($urandom_range(0, 3))
            0: w.smp = 32'sh8000_0000;
            1: w.smp = 32'sh7FFF_FFFF;
            2: w.smp = '0;
            default: w.smp = -1;
         endcase
      else
         w.smp = $urandom;
      return w;
   endfunction

   task automatic push_sample(int j, int q, logic signed [DATA_W-1:0] s);
      sample_word_type w;
      w.joint = JOINT_W'(j);
      w.qty   = QTY_W'(q);
      w.smp   = s;
      pending_samples.push_back(w);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_tvalid || expected_ranks.size() != 0)
         @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_rank(logic [RANK_W-1:0] r);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      rank_setting = r;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   logic [RANK_W-1:0] phase_rank [7];

   initial begin
      for (int c = 0; c < CHANNELS; c++)
         for (int s = 0; s < WIN; s++) begin
            win_value[c][s] = '0;
            win_age[c][s]   = s;
         end
      for (int k = 0; k < HOT_COUNT; k++) begin
         hot_joint[k] = JOINT_W'($urandom_range(0, JOINTS - 1));
         hot_qty[k]   = QTY_W'($urandom_range(0, QTYS - 1));
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, ties, moves both ways, under the reset rank
      push_sample(0, 0, 32'sh7FFF_FFFF);
      push_sample(0, 0, 32'sh8000_0000);
      push_sample(0, 0, 0);
      push_sample(0, 0, -1);
      push_sample(0, 0, 32'sh7FFF_FFFF);
      push_sample(0, 0, 5);
      push_sample(0, 0, 5);
      push_sample(0, 0, 5);
      push_sample(0, 0, -3);
      push_sample(0, 0, 100);
      push_sample(0, 0, 5);
      push_sample(JOINTS - 1, QTYS - 1, 32'sh8000_0000);
      push_sample(JOINTS - 1, QTYS - 1, 32'sh7FFF_FFFF);
      push_sample(JOINTS - 1, QTYS - 1, 1);
      push_sample(JOINTS - 1, QTYS - 1, -1);
      push_sample(JOINTS - 1, QTYS - 1, 32'sh5555_AAAA);
      push_sample(JOINTS - 1, QTYS - 1, 32'shAAAA_5555);
      push_sample(JOINTS - 1, 0, 32'sh0001_0000);
      push_sample(0, QTYS - 1, -32'sh0001_0000);
      push_sample(21, 10, 32'sh1234_5678);
      wait_drained();

      phase_rank[0] = 0;
      phase_rank[1] = 4;
      phase_rank[2] = 31;
      phase_rank[3] = 1;
      phase_rank[4] = RANK_W'(WIN);
      phase_rank[5] = 3;
      phase_rank[6] = RANK_W'($urandom_range(0, 31));
      for (int p = 0; p < 7; p++) begin
         write_rank(phase_rank[p]);
         idle_on = (p < 6);
         for (int n = 0; n < 150; n++)
            pending_samples.push_back(random_sample());
         // long receiver hold-off while the sender keeps offering
         if (p == 1)
            holds_asked = holds_asked + 1;
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

@@ sliding_window_rank_filter.f @@
rtl/swrf_pkg.sv
rtl/sliding_window_rank_filter.sv
test/sliding_window_rank_filter_tb.sv
